// ----- sv/length_prefix_deframer_core_defines.svh -----
// assertion macros for the length prefix deframer checker
`ifndef LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH

// same cycle implication, sampled on clk, off while rst is high
`define LPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication, sampled on clk, off while rst is high
`define LPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lpd_pkg.sv -----
// types and constants shared by the length prefix deframer
package lpd_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 32;
  localparam int LIMIT_W  = 31;
  localparam int COUNT_W  = 3;
  localparam int KIND_W   = 2;
  localparam int ERR_W    = 2;

  localparam logic [COUNT_W-1:0] HDR_BYTES   = 3'd4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1048576;

  localparam logic [KIND_W-1:0] KIND_HDR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IGN = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LIMIT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] header_count;
    logic [LEN_W-1:0]   length_word;
    logic [LIMIT_W-1:0] bytes_remaining;
    logic [ERR_W-1:0]   error_latch;
  } lpd_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] byte_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic [LEN_W-1:0]  frame_length;
    logic [ERR_W-1:0]  error_code;
  } lpd_result_t;

endpackage

// ----- sv/lpd_if.sv -----
// channel interfaces of the length prefix deframer
interface lpd_in_if import lpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface lpd_out_if import lpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] byte_kind;
  logic [BYTE_W-1:0] payload_byte;
  logic              frame_last;
  logic [LEN_W-1:0]  frame_length;
  logic [ERR_W-1:0]  error_code;
  modport source (output valid, output byte_kind, output payload_byte, output frame_last,
                  output frame_length, output error_code, input ready);
  modport sink (input valid, input byte_kind, input payload_byte, input frame_last,
                input frame_length, input error_code, output ready);
endinterface

interface lpd_cfg_if import lpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] frame_limit;
  modport source (output valid, output frame_limit, input ready);
  modport sink (input valid, input frame_limit, output ready);
endinterface

// ----- sv/lpd_step.sv -----
// next state and result for one received byte
module lpd_step import lpd_pkg::*; (
  input  lpd_state_t         state,
  input  logic [LIMIT_W-1:0] frame_limit,
  input  logic [BYTE_W-1:0]  data_byte,
  output lpd_state_t         state_next,
  output lpd_result_t        result
);

  logic [ERR_W-1:0]   err_pre;
  logic [LEN_W-1:0]   word_shift;
  logic [COUNT_W-1:0] count_inc;
  logic [LIMIT_W-1:0] remain_dec;

  always_comb begin
    err_pre = state.error_latch;
    if (state.error_latch == ERR_NONE && frame_limit == '0) begin
      err_pre = ERR_LIMIT;
    end
    word_shift = {state.length_word[LEN_W-BYTE_W-1:0], data_byte};
    count_inc  = state.header_count + 3'd1;
    remain_dec = (state.bytes_remaining != '0) ? state.bytes_remaining - 31'd1 : '0;

    state_next             = state;
    state_next.error_latch = err_pre;
    result                 = '0;
    result.error_code      = err_pre;

    if (err_pre != ERR_NONE) begin
      result.byte_kind = KIND_IGN;
    end else if (state.header_count < HDR_BYTES) begin
      state_next.length_word  = word_shift;
      state_next.header_count = count_inc;
      result.byte_kind        = KIND_HDR;
      if (count_inc == HDR_BYTES) begin
        result.frame_length = word_shift;
        if (word_shift == '0) begin
          state_next.error_latch = ERR_ZERO;
        end else if (word_shift > {1'b0, frame_limit}) begin
          state_next.error_latch = ERR_OVER;
        end else begin
          state_next.bytes_remaining = word_shift[LIMIT_W-1:0];
        end
        result.error_code = state_next.error_latch;
      end
    end else begin
      state_next.bytes_remaining = remain_dec;
      result.byte_kind           = KIND_PAY;
      result.payload_byte        = data_byte;
      result.frame_length        = state.length_word;
      if (remain_dec == '0) begin
        state_next.header_count = '0;
        state_next.length_word  = '0;
        result.frame_last       = 1'b1;
      end
    end
  end

endmodule

// ----- sv/lpd_skid.sv -----
// output register with a skid entry so the input side never waits on a stall edge
module lpd_skid import lpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  lpd_result_t up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output lpd_result_t dn_data
);

  logic        main_valid;
  logic        skid_valid;
  lpd_result_t main_data;
  lpd_result_t skid_data;
  logic        up_take;

  assign up_ready = !skid_valid;
  assign up_take  = up_valid && up_ready;
  assign dn_valid = main_valid;
  assign dn_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || dn_ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= up_take;
      end
    end else if (up_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || dn_ready) begin
      main_data <= skid_valid ? skid_data : up_data;
    end
    if (up_take) begin
      skid_data <= up_data;
    end
  end

endmodule

// ----- sv/length_prefix_deframer_core.sv -----
// top level of the length prefix deframer
// rx carries one stream byte per transaction; every accepted byte gives exactly
// one transaction on tx, in order: a header byte, a payload byte (with the
// frame length and a last flag) or a byte ignored after a sticky error
// a frame is a four byte big endian length followed by that many payload bytes
// cfg writes frame_limit at any time it is valid; ready is always high, and
// the new limit is used from the next accepted byte on
// each result is registered before it reaches tx, via the skid entry on a stall
// throughput: one byte per cycle while the skid entry is empty, set by the
// single step of header/length logic between the input and the output register
// when tx stalls, the output register and one skid entry absorb results;
// rx ready drops only once the skid entry is full
// rst (synchronous, active high) clears the frame state and the sticky error,
// empties the output register and restores frame_limit to 1048576
module length_prefix_deframer_core import lpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  lpd_in_if.sink       rx,
  lpd_out_if.source    tx,
  lpd_cfg_if.sink      cfg
);

  lpd_state_t         state;
  lpd_state_t         state_next;
  lpd_result_t        result;
  lpd_result_t        tx_data;
  logic [LIMIT_W-1:0] frame_limit;
  logic               rx_take;

  assign cfg.ready = 1'b1;
  assign rx_take   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      frame_limit <= cfg.frame_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (rx_take) begin
      state <= state_next;
    end
  end

  lpd_step u_step (
    .state       (state),
    .frame_limit (frame_limit),
    .data_byte   (rx.data_byte),
    .state_next  (state_next),
    .result      (result)
  );

  lpd_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (rx.valid),
    .up_ready (rx.ready),
    .up_data  (result),
    .dn_valid (tx.valid),
    .dn_ready (tx.ready),
    .dn_data  (tx_data)
  );

  assign tx.byte_kind    = tx_data.byte_kind;
  assign tx.payload_byte = tx_data.payload_byte;
  assign tx.frame_last   = tx_data.frame_last;
  assign tx.frame_length = tx_data.frame_length;
  assign tx.error_code   = tx_data.error_code;

endmodule

// ----- sv/lpd_checker.sv -----
// port level checks on the length prefix deframer, bound to the top level
`include "length_prefix_deframer_core_defines.svh"

module lpd_checker import lpd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              tx_valid,
  input logic              tx_ready,
  input logic [KIND_W-1:0] byte_kind,
  input logic [BYTE_W-1:0] payload_byte,
  input logic              frame_last,
  input logic [LEN_W-1:0]  frame_length,
  input logic [ERR_W-1:0]  error_code
);

  `LPD_ASSERT_NEXT(a_tx_hold, tx_valid && !tx_ready, tx_valid && $stable(payload_byte) && $stable(frame_length) && $stable(byte_kind), "tx transaction changed while stalled")
  `LPD_ASSERT_NOW(a_kind_legal, tx_valid, byte_kind == KIND_HDR || byte_kind == KIND_PAY || byte_kind == KIND_IGN, "illegal byte_kind")
  `LPD_ASSERT_NOW(a_non_payload_clear, tx_valid && byte_kind != KIND_PAY, payload_byte == '0 && frame_last == 1'b0, "payload fields set on non payload transaction")
  `LPD_ASSERT_NOW(a_ignored_has_error, tx_valid && byte_kind == KIND_IGN, error_code != ERR_NONE && frame_length == '0, "ignored byte without latched error")
  `LPD_ASSERT_NOW(a_payload_no_error, tx_valid && byte_kind == KIND_PAY, error_code == ERR_NONE && frame_length != '0, "payload byte with error or zero length")

endmodule

bind length_prefix_deframer_core lpd_checker u_lpd_checker (
  .clk          (clk),
  .rst          (rst),
  .tx_valid     (tx.valid),
  .tx_ready     (tx.ready),
  .byte_kind    (tx.byte_kind),
  .payload_byte (tx.payload_byte),
  .frame_last   (tx.frame_last),
  .frame_length (tx.frame_length),
  .error_code   (tx.error_code)
);

// ----- tb/tb.sv -----
// self-checking testbench for length_prefix_deframer_core: framed byte streams with checked results
`timescale 1ns / 1ps

module tb import lpd_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {SEND_BYTE, SET_LIMIT, WAIT_IDLE} stream_op_e;

  typedef struct packed {
    stream_op_e       op;
    logic [LEN_W-1:0] value;
  } stream_op_t;

  logic clk;
  logic rst;

  lpd_in_if  rx_ch ();
  lpd_out_if tx_ch ();
  lpd_cfg_if cfg_ch ();

  length_prefix_deframer_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch),
    .cfg (cfg_ch)
  );

  stream_op_t  stream_q[$];
  lpd_result_t deframed_q[$];

  // deframer state as predicted
  logic [COUNT_W-1:0] hdr_seen;
  logic [LEN_W-1:0]   frame_len;
  logic [LIMIT_W-1:0] frame_left;
  logic [ERR_W-1:0]   sticky_err;
  logic [LIMIT_W-1:0] limit_now;

  logic [LIMIT_W-1:0] gen_limit;
  int                 mismatches;
  int unsigned        cycle_count;
  int                 gap_left;
  int                 stall_left;
  int                 quiet_cycles;
  logic               byte_taken;
  logic               limit_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    lpd_result_t r;
    r = '0;
    if (sticky_err == ERR_NONE && limit_now == '0) sticky_err = ERR_LIMIT;
    if (sticky_err != ERR_NONE) begin
      r.byte_kind = KIND_IGN;
      r.error_code = sticky_err;
    end else if (hdr_seen < HDR_BYTES) begin
      frame_len = {frame_len[LEN_W-BYTE_W-1:0], b};
      hdr_seen = hdr_seen + 1'b1;
      r.byte_kind = KIND_HDR;
      if (hdr_seen == HDR_BYTES) begin
        if (frame_len == '0) sticky_err = ERR_ZERO;
        else if (frame_len > {1'b0, limit_now}) sticky_err = ERR_OVER;
        else frame_left = frame_len[LIMIT_W-1:0];
        r.frame_length = frame_len;
        r.error_code = sticky_err;
      end
    end else begin
      if (frame_left != '0) frame_left = frame_left - 1'b1;
      r.byte_kind = KIND_PAY;
      r.payload_byte = b;
      r.frame_length = frame_len;
      if (frame_left == '0) begin
        r.frame_last = 1'b1;
        hdr_seen = '0;
        frame_len = '0;
      end
    end
    deframed_q.insert(deframed_q.size(), r);
  endfunction

  function automatic void add_op(input stream_op_e op, input logic [LEN_W-1:0] value);
    stream_op_t s;
    s.op = op;
    s.value = value;
    stream_q.insert(stream_q.size(), s);
  endfunction

  function automatic void add_byte(input logic [BYTE_W-1:0] b);
    add_op(SEND_BYTE, LEN_W'(b));
  endfunction

  function automatic void add_limit(input logic [LIMIT_W-1:0] lim);
    add_op(SET_LIMIT, LEN_W'(lim));
    gen_limit = lim;
  endfunction

  function automatic void add_header(input logic [LEN_W-1:0] len);
    for (int k = 3; k >= 0; k--) add_byte(len[8*k +: 8]);
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 31'd1;
      1: return LIMIT_W'($urandom_range(2, 48));
      2: return LIMIT_W'($urandom_range(49, 5000));
      3: return 31'h7fffffff;
      4: return LIMIT_RESET;
      default: return LIMIT_W'($urandom_range(1, 32'h7fffffff));
    endcase
  endfunction

  // random payload, with the odd limit change in the middle of the frame
  function automatic void add_frame(input int unsigned len);
    add_header(LEN_W'(len));
    for (int unsigned i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 99) == 0) add_limit(pick_limit());
      add_byte(BYTE_W'($urandom));
    end
  endfunction

  task automatic note_mismatch(input string field, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
    if (mismatches < 40)
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
    mismatches++;
  endtask

  function automatic logic calm();
    return stream_q.size() < 250;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin : handshake_track
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_now = cfg_ch.frame_limit;
        limit_taken = 1'b1;
      end
      if (rx_ch.valid && rx_ch.ready) begin
        deframe_byte(rx_ch.data_byte);
        byte_taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin : stream_driver
    logic               nv;
    logic               ncv;
    logic [BYTE_W-1:0]  nd;
    logic [LIMIT_W-1:0] nl;
    nv = rx_ch.valid;
    nd = rx_ch.data_byte;
    ncv = cfg_ch.valid;
    nl = cfg_ch.frame_limit;
    if (byte_taken) nv = 1'b0;
    if (limit_taken) ncv = 1'b0;
    byte_taken = 1'b0;
    limit_taken = 1'b0;
    if (!nv && deframed_q.size() == 0) quiet_cycles++;
    else quiet_cycles = 0;
    if (!rst && !nv && !ncv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (stream_q.size() > 0) begin
        case (stream_q[0].op)
          SEND_BYTE: begin
            if (!calm() && !cycle_count[7] && $urandom_range(0, 4) == 0) begin
              gap_left = $urandom_range(0, 2);
            end else begin
              nv = 1'b1;
              nd = stream_q[0].value[BYTE_W-1:0];
              void'(stream_q.pop_front());
            end
          end
          SET_LIMIT: begin
            if (quiet_cycles >= 2) begin
              ncv = 1'b1;
              nl = stream_q[0].value[LIMIT_W-1:0];
              void'(stream_q.pop_front());
            end
          end
          default: begin
            if (quiet_cycles >= 2) void'(stream_q.pop_front());
          end
        endcase
      end
    end
    rx_ch.valid <= nv;
    rx_ch.data_byte <= nd;
    cfg_ch.valid <= ncv;
    cfg_ch.frame_limit <= nl;
  end

  always @(negedge clk) begin : sink_stall
    logic nr;
    nr = 1'b1;
    if (stall_left > 0) begin
      nr = 1'b0;
      stall_left--;
    end else if (!rst && !calm() && cycle_count[8:7] != 2'b11 && $urandom_range(0, 4) == 0) begin
      nr = 1'b0;
      stall_left = $urandom_range(0, 2);
    end
    tx_ch.ready <= nr;
  end

  always @(posedge clk) begin : result_check
    lpd_result_t want;
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      if (deframed_q.size() == 0) begin
        if (mismatches < 40)
          $display("%0t unexpected transaction: expected none, actual kind %0d length %0h",
                   $time, tx_ch.byte_kind, tx_ch.frame_length);
        mismatches++;
      end else begin
        want = deframed_q.pop_front();
        if (tx_ch.byte_kind !== want.byte_kind)
          note_mismatch("byte_kind", LEN_W'(want.byte_kind), LEN_W'(tx_ch.byte_kind));
        if (tx_ch.payload_byte !== want.payload_byte)
          note_mismatch("payload_byte", LEN_W'(want.payload_byte), LEN_W'(tx_ch.payload_byte));
        if (tx_ch.frame_last !== want.frame_last)
          note_mismatch("frame_last", LEN_W'(want.frame_last), LEN_W'(tx_ch.frame_last));
        if (tx_ch.frame_length !== want.frame_length)
          note_mismatch("frame_length", want.frame_length, tx_ch.frame_length);
        if (tx_ch.error_code !== want.error_code)
          note_mismatch("error_code", LEN_W'(want.error_code), LEN_W'(tx_ch.error_code));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL length_prefix_deframer_core");
    $finish;
  end

  initial begin
    int unsigned cap;
    int unsigned len;
    int          pick;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.data_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.frame_limit = '0;
    tx_ch.ready = 1'b0;
    hdr_seen = '0;
    frame_len = '0;
    frame_left = '0;
    sticky_err = ERR_NONE;
    limit_now = LIMIT_RESET;
    gen_limit = LIMIT_RESET;
    mismatches = 0;
    cycle_count = 0;
    gap_left = 0;
    stall_left = 0;
    quiet_cycles = 0;
    byte_taken = 1'b0;
    limit_taken = 1'b0;

    // directed: shortest frames, limit extremes, limit change inside a frame
    add_header(32'd1);
    add_byte(8'hff);
    add_limit(31'h7fffffff);
    add_header(32'd2);
    add_byte(8'h00);
    add_byte(8'h5a);
    add_limit(31'd1);
    add_header(32'd1);
    add_byte(8'ha5);
    add_limit(31'd4);
    add_header(32'd4);
    add_byte(8'h80);
    add_limit(31'd1);
    add_byte(8'h01);
    add_byte(8'h02);
    add_byte(8'h7f);

    // random well-formed frames under changing limits
    add_limit(pick_limit());
    while (stream_q.size() < 1800) begin
      if ($urandom_range(0, 9) == 0) add_limit(pick_limit());
      if ($urandom_range(0, 24) == 0) add_op(WAIT_IDLE, '0);
      cap = (gen_limit < 40) ? int'(gen_limit) : 40;
      pick = $urandom_range(0, 9);
      if (pick == 0) len = cap;
      else if (pick < 3) len = $urandom_range(1, cap);
      else len = $urandom_range(1, (cap < 12) ? cap : 12);
      add_frame(len);
    end

    // one sticky error at the end, then bytes that must be ignored
    case ($urandom_range(0, 2))
      0: begin
        add_limit(31'd200);
        add_header(($urandom_range(0, 1) == 0) ? 32'd201 : 32'hffffffff);
      end
      1: add_header(32'd0);
      default: begin
        add_limit(31'h7fffffff);
        add_header(32'h7fffffff);
        repeat (6) add_byte(BYTE_W'($urandom));
        add_limit('0);
      end
    endcase
    repeat (12) add_byte(BYTE_W'($urandom));
    add_limit('0);
    repeat (5) add_byte(BYTE_W'($urandom));
    add_limit(LIMIT_RESET);
    repeat (5) add_byte(BYTE_W'($urandom));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stream_q.size() > 0 || rx_ch.valid || cfg_ch.valid || deframed_q.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS length_prefix_deframer_core");
    end else begin
      $display("FAIL length_prefix_deframer_core");
    end
    $finish;
  end

endmodule

// ----- length_prefix_deframer_core.f -----
+incdir+sv
sv/lpd_pkg.sv
sv/lpd_if.sv
sv/lpd_step.sv
sv/lpd_skid.sv
sv/length_prefix_deframer_core.sv
sv/lpd_checker.sv
tb/tb.sv
